>>> design/bhgd_pkg.sv
// ----------------------------------------------------------------------------
// Button history gesture detector package
// Shared types, constants and the stick decode for the detector modules.
// ----------------------------------------------------------------------------
package bhgd_pkg;

    localparam int HIST_DEPTH = 32;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int BTN_W      = 18;
    localparam int STICK_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int LANES      = BTN_W + 1;

    // Oldest frame that any search reaches.
    localparam logic [HIST_AW-1:0] LAST_AGO = HIST_AW'(HIST_DEPTH - 1);

    localparam int B_UP       = 7;
    localparam int B_DOWN     = 8;
    localparam int B_LEFT     = 9;
    localparam int B_RIGHT    = 10;
    localparam int B_UI_LEFT  = 13;
    localparam int B_UI_RIGHT = 14;

    localparam logic [STICK_W-1:0] STICK_NEUTRAL    = 4'd0;
    localparam logic [STICK_W-1:0] STICK_UP         = 4'd1;
    localparam logic [STICK_W-1:0] STICK_UP_RIGHT   = 4'd2;
    localparam logic [STICK_W-1:0] STICK_RIGHT      = 4'd3;
    localparam logic [STICK_W-1:0] STICK_DOWN_RIGHT = 4'd4;
    localparam logic [STICK_W-1:0] STICK_DOWN       = 4'd5;
    localparam logic [STICK_W-1:0] STICK_DOWN_LEFT  = 4'd6;
    localparam logic [STICK_W-1:0] STICK_LEFT       = 4'd7;
    localparam logic [STICK_W-1:0] STICK_UP_LEFT    = 4'd8;
    localparam logic [STICK_W-1:0] STICK_NONE       = 4'd15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_HOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_GAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHORD_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_BUTTON = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_WINDOW = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        LN_SEARCH,
        LN_HOLD,
        LN_HIT,
        LN_MISS
    } t_lane;

    typedef struct packed {
        logic               start;
        logic               rd_en;
        logic [HIST_AW-1:0] rd_ago;
        logic               finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [3:0]  tap_hold;
        logic [3:0]  tap_gap;
        logic [17:0] chord_mask;
        logic [4:0]  rot_button;
        logic [4:0]  rot_window;
    } t_cfg;

    function automatic logic [STICK_W-1:0] stick_of(input logic [BTN_W-1:0] s);
        logic [STICK_W-1:0] code;
        if (s[B_UP]) begin
            code = s[B_RIGHT] ? STICK_UP_RIGHT : (s[B_LEFT] ? STICK_UP_LEFT : STICK_UP);
        end else if (s[B_DOWN]) begin
            code = s[B_RIGHT] ? STICK_DOWN_RIGHT :
                   (s[B_LEFT] ? STICK_DOWN_LEFT : STICK_DOWN);
        end else if (s[B_UI_RIGHT]) begin
            code = STICK_RIGHT;
        end else if (s[B_UI_LEFT]) begin
            code = STICK_LEFT;
        end else begin
            code = STICK_NEUTRAL;
        end
        return code;
    endfunction

endpackage

>>> design/bhgd_in_if.sv
// ----------------------------------------------------------------------------
// Frame input channel
// Valid/ready channel carrying one frame's button vector.
// ----------------------------------------------------------------------------
interface bhgd_in_if;
    logic        valid;
    logic        ready;
    logic [17:0] frame_buttons;

    modport source (output valid, output frame_buttons, input ready);
    modport sink   (input valid, input frame_buttons, output ready);
endinterface

>>> design/bhgd_out_if.sv
// ----------------------------------------------------------------------------
// Gesture result channel
// Valid/ready channel carrying one frame's edges and gesture flags.
// ----------------------------------------------------------------------------
interface bhgd_out_if;
    logic        valid;
    logic        ready;
    logic [17:0] held_now;
    logic [17:0] press_edges;
    logic [17:0] release_edges;
    logic [17:0] double_taps;
    logic [3:0]  stick_code;
    logic        stick_push_valid;
    logic [3:0]  stick_double_code;
    logic        chord_hit;
    logic        rotation_hit;

    modport source (output valid, output held_now, output press_edges,
                    output release_edges, output double_taps, output stick_code,
                    output stick_push_valid, output stick_double_code,
                    output chord_hit, output rotation_hit, input ready);
    modport sink   (input valid, input held_now, input press_edges,
                    input release_edges, input double_taps, input stick_code,
                    input stick_push_valid, input stick_double_code,
                    input chord_hit, input rotation_hit, output ready);
endinterface

>>> design/bhgd_ctrl.sv
// ----------------------------------------------------------------------------
// Gesture detector controller
// Sequences one frame: accept, history scan, drain, result transfer.
// ----------------------------------------------------------------------------
module bhgd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output bhgd_pkg::t_dp_cmd    o_cmd,
    input  bhgd_pkg::t_dp_status i_sts
);
    import bhgd_pkg::*;

    t_state             r_state, n_state;
    logic [HIST_AW-1:0] r_addr, n_addr;

    // State and scan address registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.rd_ago = r_addr;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_addr      = HIST_AW'(1);
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_addr      = r_addr + HIST_AW'(1);
                if (r_addr == LAST_AGO) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_SCAN && r_addr == HIST_AW'(1)))
        else $error("accepted frame did not start a scan");
    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_addr != '0))
        else $error("scan reached the current frame slot");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("result loaded while output register busy");
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_addr == LAST_AGO) |=> (r_state == ST_DRAIN))
        else $error("scan did not end after the oldest frame");

endmodule

>>> design/bhgd_dp.sv
// ----------------------------------------------------------------------------
// Gesture detector datapath
// History memory, per-button search lanes, chord/rotation flags, output register.
// ----------------------------------------------------------------------------
module bhgd_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bhgd_pkg::t_dp_cmd    i_cmd,
    output bhgd_pkg::t_dp_status o_sts,
    input  bhgd_pkg::t_cfg       i_cfg,
    input  logic [17:0]          i_frame,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [17:0]          o_held_now,
    output logic [17:0]          o_press_edges,
    output logic [17:0]          o_release_edges,
    output logic [17:0]          o_double_taps,
    output logic [3:0]           o_stick_code,
    output logic                 o_stick_push_valid,
    output logic [3:0]           o_stick_double_code,
    output logic                 o_chord_hit,
    output logic                 o_rotation_hit
);
    import bhgd_pkg::*;

    logic [BTN_W-1:0]   mem [HIST_DEPTH];
    logic [HIST_AW-1:0] r_head;
    logic [HIST_AW-1:0] r_fill;
    logic [HIST_AW-1:0] wr_slot;
    logic [BTN_W-1:0]   r_rd_data;
    logic               r_rd_vld;
    logic [HIST_AW-1:0] r_rd_ago;

    logic [BTN_W-1:0]   r_cur;
    logic [STICK_W-1:0] cur_stick;
    logic [BTN_W-1:0]   r_h1, r_h2, r_h3;
    logic               r_push;
    logic [3:0]         r_dir, n_dir;   // up, right, down, left

    t_lane              r_lane [LANES];
    t_lane              n_lane [LANES];
    logic [3:0]         r_cnt  [LANES];
    logic [3:0]         n_cnt  [LANES];

    logic               ent_vld;
    logic [BTN_W-1:0]   ent_btn;
    logic [STICK_W-1:0] ent_stick;
    logic [LANES-1:0]   ent_on;
    logic               past_gap;
    logic               in_rot;

    logic [BTN_W-1:0]   dbl;
    logic [STICK_W-1:0] sdbl;
    logic               chord;
    logic               rot;
    logic               rot_btn_ok;
    logic               r_out_vld;

    assign wr_slot   = r_head + HIST_AW'(1);
    assign cur_stick = stick_of(r_cur);

    // History memory: write the finished frame, read one older frame per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            mem[wr_slot] <= r_cur;
        end
        r_rd_data <= mem[wr_slot - i_cmd.rd_ago];
        r_rd_ago  <= i_cmd.rd_ago;
    end

    // Head pointer, fill count and read tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.finish) begin
                r_head <= wr_slot;
                if (r_fill != LAST_AGO) begin
                    r_fill <= r_fill + HIST_AW'(1);
                end
            end
        end
    end

    // Decode the frame being read; unwritten frames read as empty
    assign ent_vld   = (r_rd_ago <= r_fill);
    assign ent_btn   = ent_vld ? r_rd_data : '0;
    assign ent_stick = ent_vld ? stick_of(r_rd_data) : STICK_NONE;
    assign ent_on    = {(ent_stick == cur_stick), ent_btn};
    assign past_gap  = (r_rd_ago > (HIST_AW'(i_cfg.tap_gap) + HIST_AW'(1)));
    assign in_rot    = (r_rd_ago <= i_cfg.rot_window);

    // Advance the double-tap search lanes
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_lane[i] = r_lane[i];
            n_cnt[i]  = r_cnt[i];
            if (r_rd_vld && r_rd_ago != HIST_AW'(1)) begin
                case (r_lane[i])
                    LN_SEARCH: begin
                        if (past_gap) begin
                            n_lane[i] = LN_MISS;
                        end else if (ent_on[i]) begin
                            n_lane[i] = (i_cfg.tap_hold == 4'd0) ? LN_MISS : LN_HOLD;
                            n_cnt[i]  = i_cfg.tap_hold;
                        end
                    end
                    LN_HOLD: begin
                        if (!ent_on[i]) begin
                            n_lane[i] = LN_HIT;
                        end else if (r_cnt[i] == 4'd1) begin
                            n_lane[i] = LN_MISS;
                        end else begin
                            n_cnt[i] = r_cnt[i] - 4'd1;
                        end
                    end
                    default: begin
                        n_lane[i] = r_lane[i];
                    end
                endcase
            end
        end
    end

    // Mark directions seen inside the rotation window
    always_comb begin
        n_dir = r_dir;
        if (r_rd_vld && in_rot) begin
            if (ent_btn[B_UP]) begin
                n_dir[0] = 1'b1;
            end else if (ent_btn[B_RIGHT]) begin
                n_dir[1] = 1'b1;
            end else if (ent_btn[B_DOWN]) begin
                n_dir[2] = 1'b1;
            end else if (ent_btn[B_LEFT]) begin
                n_dir[3] = 1'b1;
            end
        end
    end

    // Frame state: latch on start, collect during scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cur  <= i_frame;
            r_h1   <= '0;
            r_h2   <= '0;
            r_h3   <= '0;
            r_push <= 1'b0;
            r_dir  <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_lane[i] <= LN_SEARCH;
                r_cnt[i]  <= '0;
            end
        end else begin
            r_dir <= n_dir;
            for (int i = 0; i < LANES; i++) begin
                r_lane[i] <= n_lane[i];
                r_cnt[i]  <= n_cnt[i];
            end
            if (r_rd_vld) begin
                if (r_rd_ago == HIST_AW'(1)) begin
                    r_h1   <= ent_btn;
                    r_push <= (ent_stick == STICK_NEUTRAL);
                end
                if (r_rd_ago == HIST_AW'(2)) begin
                    r_h2 <= ent_btn;
                end
                if (r_rd_ago == HIST_AW'(3)) begin
                    r_h3 <= ent_btn;
                end
            end
        end
    end

    // Form the results
    always_comb begin
        for (int b = 0; b < BTN_W; b++) begin
            dbl[b] = r_cur[b] & ~r_h1[b] & (r_lane[b] == LN_HIT);
        end
    end
    assign sdbl = (r_push && cur_stick != STICK_NEUTRAL && r_lane[BTN_W] == LN_HIT) ?
                  cur_stick : STICK_NEUTRAL;
    assign chord = (i_cfg.chord_mask != '0)
                && ((r_cur & i_cfg.chord_mask) == i_cfg.chord_mask)
                && ((r_h1 & r_h2 & r_h3 & i_cfg.chord_mask) == '0)
                && ((~r_h1 & i_cfg.chord_mask) != '0);
    assign rot_btn_ok = (i_cfg.rot_button < 5'(BTN_W));
    assign rot = rot_btn_ok && r_cur[i_cfg.rot_button]
              && !r_h1[i_cfg.rot_button] && (r_dir == 4'hF);

    // Output register: load on finish, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_held_now          <= r_cur;
            o_press_edges       <= r_cur & ~r_h1;
            o_release_edges     <= ~r_cur & r_h1;
            o_double_taps       <= dbl;
            o_stick_code        <= cur_stick;
            o_stick_push_valid  <= r_push;
            o_stick_double_code <= sdbl;
            o_chord_hit         <= chord;
            o_rotation_hit      <= rot;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    a_read_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |=> (r_rd_vld && r_rd_ago == $past(i_cmd.rd_ago)))
        else $error("read tag lost");
    a_head_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_head == $past(r_head) + HIST_AW'(1)))
        else $error("head did not advance on finish");
    a_lane_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lane[0] == LN_HOLD) |-> (r_cnt[0] != 4'd0))
        else $error("hold lane with empty count");

endmodule

>>> design/button_history_gesture_detector_core.sv
// Takes one frame of 18 button bits per transfer and returns one result per
// frame: edges, per-button and stick double taps, stick push, chord and
// rotation. Each frame passes an accept state, a scan state that reads the
// history memory one older frame per cycle, a drain state and a finish state
// that waits for a free output register, then loads it and stores the frame.
// A new frame is accepted while the previous result still waits in the output
// register. No clearing pass follows reset.
// ----------------------------------------------------------------------------
// Gesture detector top level
// Configuration registers and the controller/datapath pair.
// ----------------------------------------------------------------------------
module button_history_gesture_detector_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bhgd_in_if.sink                       i_in,
    bhgd_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [bhgd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bhgd_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import bhgd_pkg::*;

    t_cfg       r_cfg;
    t_dp_cmd    cmd;
    t_dp_status sts;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_hold   <= 4'd4;
            r_cfg.tap_gap    <= 4'd8;
            r_cfg.chord_mask <= '0;
            r_cfg.rot_button <= '0;
            r_cfg.rot_window <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TAP_HOLD:   r_cfg.tap_hold   <= i_cfg_wdata[3:0];
                CFG_TAP_GAP:    r_cfg.tap_gap    <= i_cfg_wdata[3:0];
                CFG_CHORD_MASK: r_cfg.chord_mask <= i_cfg_wdata[17:0];
                CFG_ROT_BUTTON: r_cfg.rot_button <= i_cfg_wdata[4:0];
                CFG_ROT_WINDOW: r_cfg.rot_window <= i_cfg_wdata[4:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    bhgd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    bhgd_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_cfg               (r_cfg),
        .i_frame             (i_in.frame_buttons),
        .o_out_valid         (o_out.valid),
        .i_out_ready         (o_out.ready),
        .o_held_now          (o_out.held_now),
        .o_press_edges       (o_out.press_edges),
        .o_release_edges     (o_out.release_edges),
        .o_double_taps       (o_out.double_taps),
        .o_stick_code        (o_out.stick_code),
        .o_stick_push_valid  (o_out.stick_push_valid),
        .o_stick_double_code (o_out.stick_double_code),
        .o_chord_hit         (o_out.chord_hit),
        .o_rotation_hit      (o_out.rotation_hit)
    );

endmodule
